// File: design/rpb_pkg.sv
`timescale 1ns / 1ps

package rpb_pkg;

  localparam int MAX_BUCKETS = 64;
  localparam int MAX_BATCH   = 1024;

  localparam int BKT_W  = $clog2(MAX_BUCKETS);
  localparam int FILL_W = $clog2(MAX_BATCH);
  localparam int CNT_W  = FILL_W + 1;
  localparam int KEY_W  = 16;
  localparam int WID_W  = KEY_W + 1;
  localparam int BCNT_W = BKT_W + 1;
  localparam int DCNT_W = $clog2(KEY_W + 1);

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  localparam logic [1:0] REG_BUCKET_WIDTH  = 2'd0;
  localparam logic [1:0] REG_BUCKET_COUNT  = 2'd1;
  localparam logic [1:0] REG_BATCH_RECORDS = 2'd2;

  localparam logic [WID_W-1:0]  RST_BUCKET_WIDTH  = WID_W'(65536);
  localparam logic [BCNT_W-1:0] RST_BUCKET_COUNT  = BCNT_W'(1);
  localparam logic [CNT_W-1:0]  RST_BATCH_RECORDS = CNT_W'(1000);

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOOKUP,
    ST_UPDATE,
    ST_SCAN,
    ST_SCAN_OUT
  } state_t;

endpackage

// File: design/range_partition_batcher_top.sv
`timescale 1ns / 1ps
// record: the key is divided in the divide state, then one memory read and one update; the
// result is registered once the output is free, and the next record is taken back in idle
// end of data: empty buckets are stepped over, each non-empty one up to the last is sent,
// waiting on the output, and the block returns to idle before the next transfer
// reset: synchronous; registers return to width 65536, count 1, batch 1000, and the
// per-bucket nonzero flags clear at once so every fill reads as zero

module range_partition_batcher_top (
  input  logic                            clk,
  input  logic                            rst,
  // apb
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rpb_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rpb_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rpb_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rpb_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // key_high, key_low
  input  logic                            s_axis_tuser,   // action
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [rpb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // bucket, slot, flush_count, pad
  output logic                            m_axis_tuser,   // flush
  output logic                            m_axis_tlast    // last
);
  import rpb_pkg::*;

  // configuration
  logic [WID_W-1:0]  bucket_width;
  logic [BCNT_W-1:0] bucket_count;
  logic [CNT_W-1:0]  batch_records;
  logic              cfg_write;

  logic [WID_W-1:0]  width_eff;
  logic [BCNT_W-1:0] count_eff;
  logic [BCNT_W-1:0] count_m1;
  logic [CNT_W-1:0]  batch_eff;

  // control
  state_t state;
  state_t state_next;

  logic             div_start;
  logic             div_busy;
  logic [KEY_W-1:0] quotient;
  logic [KEY_W-1:0] key;

  logic [BKT_W-1:0] cur_bucket;
  logic [BKT_W-1:0] bucket_sel;
  logic [BKT_W-1:0] mem_raddr;

  // fill memory and nonzero flags
  logic [FILL_W-1:0] fill_mem [MAX_BUCKETS];
  logic [FILL_W-1:0] rd_data;
  logic              mem_we;
  logic [MAX_BUCKETS-1:0] nz;
  logic [MAX_BUCKETS-1:0] upper_mask;
  logic              nz_set;
  logic              nz_clr;

  logic [FILL_W-1:0] fill_cur;
  logic [CNT_W-1:0]  fill_inc;
  logic              flush_hit;
  logic              scan_last;
  logic              cur_nz;
  logic              out_free;
  logic              out_load;
  logic              bucket_step;

  logic [FILL_W-1:0] res_slot;
  logic [CNT_W-1:0]  res_count;
  logic              res_flush;
  logic              res_last;

  logic [BKT_W-1:0]  out_bucket;
  logic [FILL_W-1:0] out_slot;
  logic [CNT_W-1:0]  out_count;

  // apb registers
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_width  <= RST_BUCKET_WIDTH;
      bucket_count  <= RST_BUCKET_COUNT;
      batch_records <= RST_BATCH_RECORDS;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_BUCKET_WIDTH:  bucket_width  <= pwdata[WID_W-1:0];
        REG_BUCKET_COUNT:  bucket_count  <= pwdata[BCNT_W-1:0];
        REG_BATCH_RECORDS: batch_records <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BUCKET_WIDTH:  prdata = CFG_DATA_W'(bucket_width);
      REG_BUCKET_COUNT:  prdata = CFG_DATA_W'(bucket_count);
      REG_BATCH_RECORDS: prdata = CFG_DATA_W'(batch_records);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    width_eff = (bucket_width == '0) ? WID_W'(1) : bucket_width;
    if (bucket_count == '0) begin
      count_eff = BCNT_W'(1);
    end else if (bucket_count > BCNT_W'(MAX_BUCKETS)) begin
      count_eff = BCNT_W'(MAX_BUCKETS);
    end else begin
      count_eff = bucket_count;
    end
    count_m1 = count_eff - BCNT_W'(1);
    if (batch_records == '0) begin
      batch_eff = CNT_W'(1);
    end else if (batch_records > CNT_W'(MAX_BATCH)) begin
      batch_eff = CNT_W'(MAX_BATCH);
    end else begin
      batch_eff = batch_records;
    end
  end

  rpb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (key),
    .divisor  (width_eff),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign key = {s_axis_tdata[7:0], s_axis_tdata[15:8]};

  // clamp to the last bucket in use
  assign bucket_sel = (quotient >= KEY_W'(count_eff)) ? count_m1[BKT_W-1:0]
                                                      : quotient[BKT_W-1:0];

  assign mem_raddr = (state == ST_LOOKUP) ? bucket_sel : cur_bucket;

  always_ff @(posedge clk) begin
    rd_data <= fill_mem[mem_raddr];
    if (mem_we) begin
      fill_mem[cur_bucket] <= fill_inc[FILL_W-1:0];
    end
  end

  assign cur_nz     = nz[cur_bucket];
  assign fill_cur   = cur_nz ? rd_data : '0;
  assign fill_inc   = {1'b0, fill_cur} + CNT_W'(1);
  assign flush_hit  = fill_inc >= batch_eff;
  assign upper_mask = ~((MAX_BUCKETS'(2) << cur_bucket) - MAX_BUCKETS'(1));
  assign scan_last  = (nz & upper_mask) == '0;
  assign out_free   = ~m_axis_tvalid | m_axis_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = (s_axis_tuser == ACT_FLUSH) ? ST_SCAN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (cur_nz) begin
          state_next = ST_SCAN_OUT;
        end else if (cur_bucket == BKT_W'(MAX_BUCKETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN_OUT: begin
        if (out_free && scan_last) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          state_next = ST_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    nz_set        = 1'b0;
    nz_clr        = 1'b0;
    bucket_step   = 1'b0;
    res_slot      = fill_cur;
    res_count     = flush_hit ? fill_inc : '0;
    res_flush     = flush_hit;
    res_last      = 1'b1;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = ~rst;
        div_start     = s_axis_tvalid & (s_axis_tuser == ACT_RECORD);
      end
      ST_UPDATE: begin
        out_load = out_free;
        mem_we   = out_free & ~flush_hit;
        nz_set   = out_free & ~flush_hit;
        nz_clr   = out_free & flush_hit;
      end
      ST_SCAN: begin
        bucket_step = ~cur_nz;
      end
      ST_SCAN_OUT: begin
        res_slot    = '0;
        res_count   = {1'b0, rd_data};
        res_flush   = 1'b1;
        res_last    = scan_last;
        out_load    = out_free;
        nz_clr      = out_free;
        bucket_step = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      nz    <= '0;
    end else begin
      state <= state_next;
      if (nz_set) begin
        nz[cur_bucket] <= 1'b1;
      end else if (nz_clr) begin
        nz[cur_bucket] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      cur_bucket <= '0;
    end else if (state == ST_LOOKUP) begin
      cur_bucket <= bucket_sel;
    end else if (bucket_step) begin
      cur_bucket <= cur_bucket + BKT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bucket   <= cur_bucket;
      out_slot     <= res_slot;
      out_count    <= res_count;
      m_axis_tuser <= res_flush;
      m_axis_tlast <= res_last;
    end
  end

  assign m_axis_tdata = {{(OUT_DATA_W - BKT_W - FILL_W - CNT_W){1'b0}},
                         out_count, out_slot, out_bucket};

endmodule

// File: design/rpb_div.sv
`timescale 1ns / 1ps

module rpb_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rpb_pkg::KEY_W-1:0]  dividend,
  input  logic [rpb_pkg::WID_W-1:0]  divisor,
  output logic                       busy,
  output logic [rpb_pkg::KEY_W-1:0]  quotient
);
  import rpb_pkg::*;

  logic [KEY_W-1:0]  rem;
  logic [DCNT_W-1:0] cnt;
  logic [WID_W-1:0]  shifted;
  logic              fits;

  // one quotient bit per cycle, restoring
  assign shifted = {rem, quotient[KEY_W-1]};
  assign fits    = shifted >= divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DCNT_W'(KEY_W);
    end else if (busy) begin
      cnt <= cnt - DCNT_W'(1);
      if (cnt == DCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= KEY_W'(shifted - divisor);
      end else begin
        rem <= shifted[KEY_W-1:0];
      end
      quotient <= {quotient[KEY_W-2:0], fits};
    end
  end

endmodule

// File: tb/range_partition_batcher_top_tb.sv
`timescale 1ns / 1ps

module range_partition_batcher_top_tb;
  import rpb_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 150;

  typedef struct {
    logic [BKT_W-1:0]  bucket;
    logic [FILL_W-1:0] slot;
    logic              flush;
    logic [CNT_W-1:0]  flush_cnt;
    logic              is_last;
  } partition_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr = '0;
  logic [CFG_DATA_W-1:0]  pwdata = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;   // key_high, key_low
  logic                   s_axis_tuser = 1'b0; // action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;        // bucket, slot, flush_count, pad
  logic                   m_axis_tuser;        // flush
  logic                   m_axis_tlast;        // last

  // predictor state
  logic [WID_W-1:0]  pred_width = RST_BUCKET_WIDTH;
  logic [BCNT_W-1:0] pred_count = RST_BUCKET_COUNT;
  logic [CNT_W-1:0]  pred_batch = RST_BATCH_RECORDS;
  logic [FILL_W-1:0] pred_fill [MAX_BUCKETS];
  partition_result_t pending_parts[$];
  partition_result_t exp_part;

  int  errors = 0;
  int  records_sent = 0;
  int  ends_sent = 0;
  int  parts_checked = 0;
  int  flushes_seen = 0;
  int  reg_writes = 0;
  int  quiet_cycles = 0;
  int  hold_request = 0;
  bit  gaps_on = 1'b1;

  range_partition_batcher_top uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic predict_partition(input logic act, input logic [7:0] hi, input logic [7:0] lo);
    partition_result_t r;
    int width_eff;
    int count_eff;
    int batch_eff;
    int bkt;
    int next_fill;
    int n_full;
    int k;
    if (act == ACT_RECORD) begin
      width_eff = (pred_width == '0) ? 1 : int'(pred_width);
      count_eff = (pred_count == '0) ? 1 : int'(pred_count);
      if (count_eff > MAX_BUCKETS) count_eff = MAX_BUCKETS;
      batch_eff = (pred_batch == '0) ? 1 : int'(pred_batch);
      if (batch_eff > MAX_BATCH) batch_eff = MAX_BATCH;
      bkt = int'({hi, lo}) / width_eff;
      if (bkt >= count_eff) bkt = count_eff - 1;
      r.bucket = BKT_W'(bkt);
      r.slot = pred_fill[bkt];
      r.is_last = 1'b1;
      next_fill = int'(pred_fill[bkt]) + 1;
      if (next_fill >= batch_eff) begin
        r.flush = 1'b1;
        r.flush_cnt = CNT_W'(next_fill);
        pred_fill[bkt] = '0;
      end else begin
        r.flush = 1'b0;
        r.flush_cnt = '0;
        pred_fill[bkt] = FILL_W'(next_fill);
      end
      pending_parts.push_back(r);
    end else begin
      n_full = 0;
      k = 0;
      for (int i = 0; i < MAX_BUCKETS; i++) if (pred_fill[i] != '0) n_full++;
      for (int i = 0; i < MAX_BUCKETS; i++) begin
        if (pred_fill[i] != '0) begin
          k++;
          r.bucket = BKT_W'(i);
          r.slot = '0;
          r.flush = 1'b1;
          r.flush_cnt = CNT_W'(pred_fill[i]);
          r.is_last = (k == n_full);
          pred_fill[i] = '0;
          pending_parts.push_back(r);
        end
      end
    end
  endtask

  task automatic send_item(input logic act, input logic [7:0] hi, input logic [7:0] lo);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {lo, hi};
    do @(posedge clk); while (!s_axis_tready);
    predict_partition(act, hi, lo);
    if (act == ACT_RECORD) records_sent++;
    else ends_sent++;
  endtask

  task automatic send_key(input logic [15:0] key);
    send_item(ACT_RECORD, key[15:8], key[7:0]);
  endtask

  // block must be idle before a register write
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_parts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] wdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BUCKET_WIDTH:  pred_width = wdata[WID_W-1:0];
      REG_BUCKET_COUNT:  pred_count = wdata[BCNT_W-1:0];
      REG_BATCH_RECORDS: pred_batch = wdata[CNT_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_partitioning(input int width, input int bcount, input int batch);
    settle();
    write_reg(REG_BUCKET_WIDTH, width);
    write_reg(REG_BUCKET_COUNT, bcount);
    write_reg(REG_BATCH_RECORDS, batch);
  endtask

  task automatic test_reset_defaults();
    send_key(16'h0000);
    send_key(16'hFFFF);
    send_key(16'h00FF);
    send_key(16'hFF00);
    send_item(ACT_FLUSH, 8'h00, 8'h00);
    // nothing left to flush
    send_item(ACT_FLUSH, 8'hFF, 8'hFF);
  endtask

  task automatic test_out_of_range_registers();
    set_partitioning(0, 127, 0);
    write_reg(REG_SPARE, 32'h0000_0005);
    send_key(16'h0003);
    send_key(16'h003F);
    send_key(16'hFFFF);
    set_partitioning(16384, 4, 2047);
    send_key(16'h4000);
    send_key(16'h7FFF);
    send_key(16'h5A5A);
    send_key(16'hC001);
    // batch lowered below the fill of bucket 1
    set_partitioning(16384, 4, 2);
    send_key(16'h6000);
    send_key(16'h4100);
    // count lowered, bucket 3 still holds records
    set_partitioning(16384, 2, 2);
    send_key(16'h0100);
    send_item(ACT_FLUSH, 8'h12, 8'h34);
  endtask

  task automatic test_output_backpressure();
    set_partitioning(8192, 8, 3);
    gaps_on = 1'b0;
    hold_request = 400;
    repeat (24) send_key(16'($urandom));
    gaps_on = 1'b1;
  endtask

  task automatic test_random_phase(input int width, input int bcount, input int batch,
                                   input int n_items, input bit with_gaps);
    set_partitioning(width, bcount, batch);
    gaps_on = with_gaps;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < 10) send_item(ACT_FLUSH, 8'($urandom), 8'($urandom));
      else send_key(16'($urandom));
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_settings();
    int c;
    test_random_phase(1, 64, 1, 40, 1'b1);
    test_random_phase(131071, 1, 2047, 40, 1'b1);
    test_random_phase(0, 0, 0, 30, 1'b1);
    test_random_phase(1024, 64, 3, 40, 1'b1);
    test_random_phase(16384, 4, 5, 40, 1'b0);
    repeat (3) begin
      c = $urandom_range(1, 64);
      test_random_phase(65536 / c + $urandom_range(0, 3), $urandom_range(0, 127),
                        $urandom_range(0, 12), 36, 1'b1);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // sink side ready, with random stalls and requested hold-offs
  initial begin : sink_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 99) < 25) begin
        m_axis_tready <= 1'b0;
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(15, 50);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_parts.size() == 0) begin
        $display("%0t: unexpected result, expected none, got tdata=%h tuser=%b tlast=%b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        exp_part = pending_parts.pop_front();
        compare_field("bucket", 32'(exp_part.bucket), 32'(m_axis_tdata[BKT_W-1:0]));
        compare_field("slot", 32'(exp_part.slot), 32'(m_axis_tdata[BKT_W +: FILL_W]));
        compare_field("flush", 32'(exp_part.flush), 32'(m_axis_tuser));
        compare_field("flush_count", 32'(exp_part.flush_cnt),
                      32'(m_axis_tdata[BKT_W+FILL_W +: CNT_W]));
        compare_field("last", 32'(exp_part.is_last), 32'(m_axis_tlast));
        if (m_axis_tuser) flushes_seen++;
      end
      parts_checked++;
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || (psel && penable))
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending_parts.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < MAX_BUCKETS; i++) pred_fill[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_out_of_range_registers();
    test_output_backpressure();
    test_random_settings();
    settle();
    $display("covered %0d records and %0d end-of-data items over %0d register writes",
             records_sent, ends_sent, reg_writes);
    $display("checked %0d results, %0d of them flushes, %0d errors",
             parts_checked, flushes_seen, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
